[rtl/slsfr_pkg.sv]
// ----------------------------------------------------------------------------
// slsfr_pkg
// Shared types and codes for the sync/length/sum frame receiver.
// ----------------------------------------------------------------------------
package slsfr_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PHASE_W  = 3;
	localparam int unsigned CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_TYPE = 2'd2;

	// receive phases
	localparam logic [PHASE_W-1:0] PH_SYNC1   = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SYNC2   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LENGTH  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
	localparam logic [PHASE_W-1:0] PH_CHECK   = 3'd4;

	// frame status codes
	localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_SUM = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd2;

	// length byte covers two sync bytes, itself and the checksum
	localparam logic [BYTE_W-1:0] HDR_OVERHEAD = 8'd4;
	localparam logic [BYTE_W-1:0] MIN_LENGTH   = 8'd5;

	typedef struct packed {
		logic [BYTE_W-1:0]   data_byte;
		logic [BYTE_W-1:0]   byte_index;
		logic                frame_end;
		logic [STATUS_W-1:0] frame_status;
		logic                type_matches;
	} result_t;

endpackage

[rtl/sync_length_sum_frame_receiver.sv]
// ----------------------------------------------------------------------------
// sync_length_sum_frame_receiver
// Hunts two sync bytes, reads a length byte, forwards payload bytes with
// their index and reports frame status on the checksum byte.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle while in_stall is low. The byte
// is decoded combinationally against the receive state and any result lands
// in an output register; a one-entry skid register behind it lets the input
// keep flowing while a result waits, so in_stall rises only once both are full.
// When the output is free, an accepted byte's result appears the cycle after.
module sync_length_sum_frame_receiver (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [slsfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [slsfr_pkg::BYTE_W-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [slsfr_pkg::BYTE_W-1:0]       rx_byte,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [slsfr_pkg::BYTE_W-1:0]       data_byte,
	output logic [slsfr_pkg::BYTE_W-1:0]       byte_index,
	output logic                               frame_end,
	output logic [slsfr_pkg::STATUS_W-1:0]     frame_status,
	output logic                               type_matches
);

	logic [slsfr_pkg::BYTE_W-1:0]  first_sync_q;
	logic [slsfr_pkg::BYTE_W-1:0]  second_sync_q;
	logic [slsfr_pkg::BYTE_W-1:0]  accept_type_q;

	logic [slsfr_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [slsfr_pkg::BYTE_W-1:0]  left_q, left_d;
	logic [slsfr_pkg::BYTE_W-1:0]  sum_q, sum_d;
	logic [slsfr_pkg::BYTE_W-1:0]  pos_q, pos_d;
	logic                          tmatch_q, tmatch_d;

	slsfr_pkg::result_t res;
	logic               res_valid;

	slsfr_pkg::result_t out_q, skid_q;
	logic               out_valid_q, skid_valid_q;

	logic accept;
	logic out_free;

	assign in_stall = skid_valid_q;
	assign accept   = in_valid & ~skid_valid_q;
	assign out_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= '0;
			second_sync_q <= '0;
			accept_type_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				slsfr_pkg::CFG_FIRST_SYNC:  first_sync_q  <= cfg_data;
				slsfr_pkg::CFG_SECOND_SYNC: second_sync_q <= cfg_data;
				slsfr_pkg::CFG_ACCEPT_TYPE: accept_type_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		phase_d   = phase_q;
		left_d    = left_q;
		sum_d     = sum_q;
		pos_d     = pos_q;
		tmatch_d  = tmatch_q;
		res_valid = 1'b0;
		res       = '{data_byte: rx_byte, byte_index: '0, frame_end: 1'b0,
			frame_status: slsfr_pkg::ST_GOOD, type_matches: 1'b0};
		case (phase_q)
			slsfr_pkg::PH_SYNC1: begin
				if (rx_byte == first_sync_q) begin
					sum_d   = rx_byte;
					phase_d = slsfr_pkg::PH_SYNC2;
				end
			end
			slsfr_pkg::PH_SYNC2: begin
				if (rx_byte == second_sync_q) begin
					sum_d   = sum_q + rx_byte;
					phase_d = slsfr_pkg::PH_LENGTH;
				end else begin
					phase_d = slsfr_pkg::PH_SYNC1;
				end
			end
			slsfr_pkg::PH_LENGTH: begin
				if (rx_byte < slsfr_pkg::MIN_LENGTH) begin
					phase_d            = slsfr_pkg::PH_SYNC1;
					res_valid          = 1'b1;
					res.frame_end      = 1'b1;
					res.frame_status   = slsfr_pkg::ST_BAD_LEN;
				end else begin
					sum_d    = sum_q + rx_byte;
					left_d   = rx_byte - slsfr_pkg::HDR_OVERHEAD;
					pos_d    = '0;
					tmatch_d = 1'b0;
					phase_d  = slsfr_pkg::PH_PAYLOAD;
				end
			end
			slsfr_pkg::PH_PAYLOAD: begin
				if (pos_q == '0)
					tmatch_d = (rx_byte == accept_type_q);
				sum_d  = sum_q + rx_byte;
				pos_d  = pos_q + 8'd1;
				left_d = left_q - 8'd1;
				// last payload byte when the counter is about to hit zero
				if (left_q == 8'd1)
					phase_d = slsfr_pkg::PH_CHECK;
				res_valid      = 1'b1;
				res.byte_index = pos_q;
			end
			slsfr_pkg::PH_CHECK: begin
				phase_d          = slsfr_pkg::PH_SYNC1;
				res_valid        = 1'b1;
				res.frame_end    = 1'b1;
				res.frame_status = (rx_byte == sum_q) ? slsfr_pkg::ST_GOOD
					: slsfr_pkg::ST_BAD_SUM;
				res.type_matches = tmatch_q;
			end
			default: begin
				phase_d = slsfr_pkg::PH_SYNC1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= slsfr_pkg::PH_SYNC1;
			left_q   <= '0;
			sum_q    <= '0;
			pos_q    <= '0;
			tmatch_q <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			sum_q    <= sum_d;
			pos_q    <= pos_d;
			tmatch_q <= tmatch_d;
		end
	end

	// output register with skid entry; while the skid holds a request no byte
	// is accepted, so the two never compete for the output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept & res_valid;
			end
		end else if (accept && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (accept && res_valid)
				out_q <= res;
		end else if (accept && res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign data_byte    = out_q.data_byte;
	assign byte_index   = out_q.byte_index;
	assign frame_end    = out_q.frame_end;
	assign frame_status = out_q.frame_status;
	assign type_matches = out_q.type_matches;

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Frame receiver check: sends sync/length/sum frames with random content,
// broken headers, bad lengths and bad sums under random stalls on both sides,
// and compares every payload byte and frame status with a frame tracker.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [slsfr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
	localparam int DRAIN_CYCLES      = 8;
	localparam int STALL_HOLD_CYCLES = 64;
	localparam int WATCHDOG_LIMIT    = 5000;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_write = 1'b0;
	logic [slsfr_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [slsfr_pkg::BYTE_W-1:0]         cfg_data = '0;
	logic                                 in_valid = 1'b0;
	logic                                 in_stall;
	logic [slsfr_pkg::BYTE_W-1:0]         rx_byte = '0;
	logic                                 out_valid;
	logic                                 out_stall = 1'b0;
	logic [slsfr_pkg::BYTE_W-1:0]         data_byte;
	logic [slsfr_pkg::BYTE_W-1:0]         byte_index;
	logic                                 frame_end;
	logic [slsfr_pkg::STATUS_W-1:0]       frame_status;
	logic                                 type_matches;

	sync_length_sum_frame_receiver uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.frame_end    (frame_end),
		.frame_status (frame_status),
		.type_matches (type_matches)
	);

	// register copies
	logic [slsfr_pkg::BYTE_W-1:0] sync1_cfg = '0;
	logic [slsfr_pkg::BYTE_W-1:0] sync2_cfg = '0;
	logic [slsfr_pkg::BYTE_W-1:0] accept_type_cfg = '0;

	// frame tracker state
	logic [slsfr_pkg::PHASE_W-1:0] rx_phase = slsfr_pkg::PH_SYNC1;
	logic [slsfr_pkg::BYTE_W-1:0]  bytes_left = '0;
	logic [slsfr_pkg::BYTE_W-1:0]  running_sum = '0;
	logic [slsfr_pkg::BYTE_W-1:0]  payload_pos = '0;
	logic                          type_hit = 1'b0;

	logic [slsfr_pkg::BYTE_W-1:0] pending_bytes[$];
	slsfr_pkg::result_t           predicted_outputs[$];

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  mismatches = 0;
	int  hold_left = 0;
	bit  hold_request = 1'b0;
	bit  hold_done = 1'b0;
	int  quiet_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("tb: mismatch on %s at %0t: got %0d, want %0d", what, $realtime, got, want);
		mismatches++;
	endtask

	// advances the frame tracker by one received byte
	task automatic track_frame_byte(input logic [slsfr_pkg::BYTE_W-1:0] b);
		slsfr_pkg::result_t r;
		r = '0;
		case (rx_phase)
			slsfr_pkg::PH_SYNC1: begin
				if (b == sync1_cfg) begin
					running_sum = b;
					rx_phase = slsfr_pkg::PH_SYNC2;
				end
			end
			slsfr_pkg::PH_SYNC2: begin
				if (b == sync2_cfg) begin
					running_sum = running_sum + b;
					rx_phase = slsfr_pkg::PH_LENGTH;
				end else begin
					rx_phase = slsfr_pkg::PH_SYNC1;
				end
			end
			slsfr_pkg::PH_LENGTH: begin
				if (b < slsfr_pkg::MIN_LENGTH) begin
					rx_phase = slsfr_pkg::PH_SYNC1;
					r.data_byte = b;
					r.frame_end = 1'b1;
					r.frame_status = slsfr_pkg::ST_BAD_LEN;
					predicted_outputs.push_back(r);
				end else begin
					running_sum = running_sum + b;
					bytes_left = b - slsfr_pkg::HDR_OVERHEAD;
					payload_pos = '0;
					type_hit = 1'b0;
					rx_phase = slsfr_pkg::PH_PAYLOAD;
				end
			end
			slsfr_pkg::PH_PAYLOAD: begin
				if (payload_pos == 0)
					type_hit = (b == accept_type_cfg);
				r.data_byte = b;
				r.byte_index = payload_pos;
				running_sum = running_sum + b;
				payload_pos = payload_pos + 8'd1;
				bytes_left = bytes_left - 8'd1;
				if (bytes_left == 0)
					rx_phase = slsfr_pkg::PH_CHECK;
				predicted_outputs.push_back(r);
			end
			slsfr_pkg::PH_CHECK: begin
				r.data_byte = b;
				r.frame_end = 1'b1;
				r.frame_status = (b == running_sum) ? slsfr_pkg::ST_GOOD
					: slsfr_pkg::ST_BAD_SUM;
				r.type_matches = type_hit;
				rx_phase = slsfr_pkg::PH_SYNC1;
				predicted_outputs.push_back(r);
			end
			default: begin
				rx_phase = slsfr_pkg::PH_SYNC1;
			end
		endcase
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
		end else begin
			if (in_valid && !in_stall)
				track_frame_byte(rx_byte);
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		slsfr_pkg::result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_outputs.size() == 0) begin
					report_mismatch("unexpected request", data_byte, -1);
				end else begin
					want = predicted_outputs.pop_front();
					if (data_byte !== want.data_byte)
						report_mismatch("data_byte", data_byte, want.data_byte);
					if (byte_index !== want.byte_index)
						report_mismatch("byte_index", byte_index, want.byte_index);
					if (frame_end !== want.frame_end)
						report_mismatch("frame_end", frame_end, want.frame_end);
					if (frame_status !== want.frame_status)
						report_mismatch("frame_status", frame_status, want.frame_status);
					if (type_matches !== want.type_matches)
						report_mismatch("type_matches", type_matches, want.type_matches);
				end
			end
			// one long hold-off so the skid fills and the input backs up
			if (hold_request && !hold_done && out_valid) begin
				hold_done = 1'b1;
				hold_left = STALL_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [slsfr_pkg::CFG_IDX_W-1:0] idx,
			input logic [slsfr_pkg::BYTE_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			slsfr_pkg::CFG_FIRST_SYNC:  sync1_cfg = value;
			slsfr_pkg::CFG_SECOND_SYNC: sync2_cfg = value;
			slsfr_pkg::CFG_ACCEPT_TYPE: accept_type_cfg = value;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || predicted_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// queues one frame; lengths below the minimum stop after the length byte
	task automatic queue_frame(input logic [slsfr_pkg::BYTE_W-1:0] len, input bit bad_sum,
			input logic [slsfr_pkg::BYTE_W-1:0] type_code);
		logic [slsfr_pkg::BYTE_W-1:0] sum;
		logic [slsfr_pkg::BYTE_W-1:0] b;
		pending_bytes.push_back(sync1_cfg);
		pending_bytes.push_back(sync2_cfg);
		pending_bytes.push_back(len);
		if (len >= slsfr_pkg::MIN_LENGTH) begin
			sum = sync1_cfg + sync2_cfg + len + type_code;
			pending_bytes.push_back(type_code);
			for (int i = 0; i < int'(len) - 5; i++) begin
				b = 8'($urandom_range(0, 255));
				sum = sum + b;
				pending_bytes.push_back(b);
			end
			if (bad_sum)
				sum = sum + 8'($urandom_range(1, 255));
			pending_bytes.push_back(sum);
		end
	endtask

	function automatic logic [slsfr_pkg::BYTE_W-1:0] byte_other_than(
			input logic [slsfr_pkg::BYTE_W-1:0] v);
		logic [slsfr_pkg::BYTE_W-1:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == v)
			b = ~v;
		return b;
	endfunction

	task automatic queue_random_traffic(input int n_bytes);
		int start;
		int pick;
		logic [slsfr_pkg::BYTE_W-1:0] type_code;
		start = pending_bytes.size();
		while (pending_bytes.size() - start < n_bytes) begin
			pick = $urandom_range(0, 99);
			type_code = ($urandom_range(0, 1) != 0) ? accept_type_cfg
				: 8'($urandom_range(0, 255));
			if (pick < 65) begin
				queue_frame(8'($urandom_range(5, ($urandom_range(0, 9) == 0) ? 40 : 14)),
					1'b0, type_code);
			end else if (pick < 77) begin
				queue_frame(8'($urandom_range(5, 14)), 1'b1, type_code);
			end else if (pick < 87) begin
				queue_frame(8'($urandom_range(0, 4)), 1'b0, type_code);
			end else if (pick < 94) begin
				pending_bytes.push_back(byte_other_than(sync1_cfg));
			end else begin
				// header broken after the first sync byte
				pending_bytes.push_back(sync1_cfg);
				pending_bytes.push_back(byte_other_than(sync2_cfg));
			end
		end
	endtask

	initial begin
		logic [slsfr_pkg::BYTE_W-1:0] s1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(slsfr_pkg::CFG_FIRST_SYNC, 8'hFF);
		write_reg(slsfr_pkg::CFG_SECOND_SYNC, 8'h00);
		write_reg(slsfr_pkg::CFG_ACCEPT_TYPE, 8'h00);
		write_reg(CFG_UNUSED_IDX, 8'h5A);

		send_idle_pct = 9;
		recv_idle_pct = 59;
		pending_bytes.push_back(8'h5A);
		pending_bytes.push_back(sync1_cfg);
		pending_bytes.push_back(8'h7E);
		queue_frame(8'd0, 1'b0, 8'h00);
		queue_frame(8'd4, 1'b0, 8'h00);
		queue_frame(8'd5, 1'b0, 8'h00);
		queue_frame(8'd6, 1'b1, 8'hFF);
		queue_random_traffic(50);
		wait_drained();

		s1 = 8'($urandom_range(0, 255));
		write_reg(slsfr_pkg::CFG_FIRST_SYNC, s1);
		write_reg(slsfr_pkg::CFG_SECOND_SYNC, byte_other_than(s1));
		write_reg(slsfr_pkg::CFG_ACCEPT_TYPE, 8'($urandom_range(0, 255)));
		send_idle_pct = 59;
		recv_idle_pct = 9;
		queue_random_traffic(50);
		wait_drained();

		write_reg(slsfr_pkg::CFG_FIRST_SYNC, 8'h00);
		write_reg(slsfr_pkg::CFG_SECOND_SYNC, 8'hFF);
		write_reg(slsfr_pkg::CFG_ACCEPT_TYPE, 8'hFF);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		queue_random_traffic(10);
		queue_frame(8'd255, 1'b0, 8'hFF);
		queue_random_traffic(10);
		wait_drained();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
